>>> rtl/core/pps_pkg.sv
package pps_pkg;

    localparam int MAX_POINTS   = 1024;
    localparam int ADDR_W       = $clog2(MAX_POINTS);
    localparam int CNT_W        = ADDR_W + 1;
    localparam int CORDIC_STEPS = 30;
    localparam int STEP_W       = 5;
    localparam int XW           = 64;
    localparam int ZW           = 36;
    localparam int DW           = 65;

    localparam logic signed [ZW-1:0] PI_Q30      = 36'sd3373259426;
    localparam logic signed [ZW-1:0] HALF_PI_Q30 = 36'sd1686629713;
    localparam logic signed [ZW-1:0] TWO_PI_Q30  = 36'sd6746518852;
    localparam logic signed [XW-1:0] GAIN_Q30    = 64'sd652032874;
    localparam logic [31:0]          DEG_PER_RAD = 32'd240315917;
    localparam logic [12:0]          SPEED_MIN   = 13'd256;
    localparam logic [12:0]          SPEED_MAX   = 13'd1536;

    typedef enum logic [2:0] {
        REG_LOOK_AHEAD  = 3'd0,
        REG_TARGET_SPD  = 3'd1,
        REG_WHEEL_BASE  = 3'd2,
        REG_STEER_RATIO = 3'd3,
        REG_STEER_LIMIT = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic [22:0] look_ahead;
        logic [12:0] target_speed;
        logic [19:0] wbase;
        logic [13:0] steer_ratio;
        logic [15:0] steer_limit;
    } cfg_t;

    typedef struct packed {
        logic signed [16:0] steer_cmd;
        logic [10:0]        speed_cmd;
        logic [9:0]         closest_index;
        logic [9:0]         target_index;
        logic signed [31:0] tgt_x;
        logic signed [31:0] tgt_y;
        logic               path_ok;
    } res_t;

    typedef struct packed {
        logic                 start;
        logic                 vector;
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
    } cordic_req_t;

    function automatic logic [29:0] atan_entry(input logic [STEP_W-1:0] i);
        logic [29:0] v;
        case (i)
            5'd0:  v = 30'd843314856;
            5'd1:  v = 30'd497837829;
            5'd2:  v = 30'd263043836;
            5'd3:  v = 30'd133525158;
            5'd4:  v = 30'd67021686;
            5'd5:  v = 30'd33543515;
            5'd6:  v = 30'd16775850;
            5'd7:  v = 30'd8388437;
            5'd8:  v = 30'd4194282;
            5'd9:  v = 30'd2097149;
            5'd10: v = 30'd1048575;
            5'd11: v = 30'd524287;
            5'd12: v = 30'd262143;
            5'd13: v = 30'd131071;
            5'd14: v = 30'd65535;
            5'd15: v = 30'd32767;
            5'd16: v = 30'd16383;
            5'd17: v = 30'd8191;
            5'd18: v = 30'd4095;
            5'd19: v = 30'd2047;
            5'd20: v = 30'd1023;
            5'd21: v = 30'd511;
            5'd22: v = 30'd255;
            5'd23: v = 30'd127;
            5'd24: v = 30'd63;
            5'd25: v = 30'd31;
            5'd26: v = 30'd15;
            5'd27: v = 30'd8;
            5'd28: v = 30'd4;
            5'd29: v = 30'd2;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage

>>> rtl/core/pps_ram.sv
module pps_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/pps_cordic.sv
module pps_cordic (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  pps_pkg::cordic_req_t          req,
    output logic                          done,
    output logic signed [pps_pkg::XW-1:0] y_out,
    output logic signed [pps_pkg::ZW-1:0] z_out
);

    logic signed [pps_pkg::XW-1:0] x_reg, y_reg, x_next, y_next, xs, ys;
    logic signed [pps_pkg::ZW-1:0] z_reg, z_next, tab;
    logic [pps_pkg::STEP_W-1:0]    step_reg;
    logic                          vector_reg, busy_reg, done_reg, sigma;

    always_comb begin
        xs  = x_reg >>> step_reg;
        ys  = y_reg >>> step_reg;
        tab = pps_pkg::ZW'(signed'({1'b0, pps_pkg::atan_entry(step_reg)}));
        // vectoring drives y to zero, rotation drives z to zero
        sigma = vector_reg ? !y_reg[pps_pkg::XW-1] : z_reg[pps_pkg::ZW-1];
        if (sigma) begin
            x_next = x_reg + ys;
            y_next = y_reg - xs;
            z_next = z_reg + tab;
        end else begin
            x_next = x_reg - ys;
            y_next = y_reg + xs;
            z_next = z_reg - tab;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == pps_pkg::STEP_W'(pps_pkg::CORDIC_STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            x_reg      <= req.x;
            y_reg      <= req.y;
            z_reg      <= req.z;
            vector_reg <= req.vector;
        end else if (busy_reg) begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign done  = done_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;

endmodule

>>> rtl/core/pps_core.sv
module pps_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  pps_pkg::cfg_t      cfg,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               req_type,
    input  logic signed [31:0] wp_x,
    input  logic signed [31:0] wp_y,
    input  logic signed [31:0] car_x,
    input  logic signed [31:0] car_y,
    input  logic signed [15:0] car_heading,
    output logic               out_valid,
    input  logic               out_ready,
    output pps_pkg::res_t      res
);

    typedef enum logic [17:0] {
        ST_IDLE = 18'h00001,
        ST_RD   = 18'h00002,
        ST_MX   = 18'h00004,
        ST_MY   = 18'h00008,
        ST_CMP  = 18'h00010,
        ST_LA   = 18'h00020,
        ST_LA2  = 18'h00040,
        ST_ATAN = 18'h00080,
        ST_ATW  = 18'h00100,
        ST_SIN  = 18'h00200,
        ST_SINW = 18'h00400,
        ST_M1   = 18'h00800,
        ST_M1W  = 18'h01000,
        ST_THW  = 18'h02000,
        ST_M2   = 18'h04000,
        ST_M3   = 18'h08000,
        ST_M4   = 18'h10000,
        ST_OUT  = 18'h20000
    } state_t;

    localparam int AW = pps_pkg::ADDR_W;
    localparam int CW = pps_pkg::CNT_W;
    localparam int XW = pps_pkg::XW;
    localparam int ZW = pps_pkg::ZW;
    localparam int DW = pps_pkg::DW;

    state_t state_reg, state_next;

    logic [CW-1:0]        cnt_reg;
    logic [AW-1:0]        start_reg, idx_reg, closest_reg, tgt_reg;
    logic                 phase2_reg, found_reg, dxneg_reg, dyneg_reg;
    logic [DW-1:0]        best_reg, la2_reg;
    logic signed [31:0]   cx_reg, cy_reg, cbx_reg, cby_reg, w0x_reg, w0y_reg;
    logic signed [31:0]   tx_reg, ty_reg, wx_reg, wy_reg;
    logic signed [15:0]   hd_reg;
    logic [31:0]          uy_reg;
    logic [63:0]          sx_reg, prod_reg;
    logic signed [ZW-1:0] atan_reg;
    logic signed [XW-1:0] s_reg;
    pps_pkg::res_t        res_reg, out_reg;
    logic                 out_valid_reg;

    logic [63:0]          ram_rdata;
    logic                 ram_we, ram_re;
    pps_pkg::cordic_req_t creq;
    logic                 cdone;
    logic signed [XW-1:0] cy_out;
    logic signed [ZW-1:0] cz_out;

    logic [31:0]          mul_a, mul_b;
    logic [CW-1:0]        last;
    logic                 at_last, in_acc;
    logic signed [31:0]   rx, ry, px, py, txu, tyu;
    logic signed [32:0]   dxw, dyw, dxt, dyt;
    logic [31:0]          ux, uyw;
    logic [DW-1:0]        dsum;
    logic signed [ZW-1:0] atan_fix, alpha, alpha_w, ang, hd_sh;
    logic [31:0]          smag, thmag, tval;
    logic [63:0]          y2, xl, t_full, m_full;
    logic [39:0]          magv;
    logic [15:0]          mag;
    logic [12:0]          spd;

    pps_ram #(.WIDTH(64), .DEPTH(pps_pkg::MAX_POINTS)) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (cnt_reg[AW-1:0]),
        .wdata ({wp_y, wp_x}),
        .re    (ram_re),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    pps_cordic u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (creq),
        .done    (cdone),
        .y_out   (cy_out),
        .z_out   (cz_out)
    );

    assign in_ready = (state_reg == ST_IDLE);
    assign in_acc   = in_valid && in_ready;
    assign ram_we   = in_acc && !req_type && (cnt_reg < CW'(pps_pkg::MAX_POINTS));
    assign ram_re   = (state_reg == ST_RD);
    assign last     = cnt_reg - CW'(2);
    assign at_last  = ({1'b0, idx_reg} == last);

    always_comb begin
        px   = ram_rdata[31:0];
        py   = ram_rdata[63:32];
        rx   = phase2_reg ? cbx_reg : cx_reg;
        ry   = phase2_reg ? cby_reg : cy_reg;
        dxw  = {px[31], px} - {rx[31], rx};
        dyw  = {py[31], py} - {ry[31], ry};
        ux   = dxw[32] ? 32'(-dxw) : dxw[31:0];
        uyw  = dyw[32] ? 32'(-dyw) : dyw[31:0];
        dsum = {1'b0, sx_reg} + {1'b0, prod_reg};

        txu  = found_reg ? tx_reg : w0x_reg;
        tyu  = found_reg ? ty_reg : w0y_reg;
        dxt  = {txu[31], txu} - {cx_reg[31], cx_reg};
        dyt  = {tyu[31], tyu} - {cy_reg[31], cy_reg};

        atan_fix = dxneg_reg ? (pps_pkg::PI_Q30 - cz_out) : cz_out;
        if (dyneg_reg) begin
            atan_fix = -atan_fix;
        end

        hd_sh = ZW'(signed'(hd_reg)) <<< 17;
        alpha = atan_reg - hd_sh;
        if (alpha > pps_pkg::PI_Q30) begin
            alpha_w = alpha - pps_pkg::TWO_PI_Q30;
        end else if (alpha <= -pps_pkg::PI_Q30) begin
            alpha_w = alpha + pps_pkg::TWO_PI_Q30;
        end else begin
            alpha_w = alpha;
        end
        // fold into the right half plane before rotating
        if (alpha_w > pps_pkg::HALF_PI_Q30) begin
            ang = pps_pkg::PI_Q30 - alpha_w;
        end else if (alpha_w < -pps_pkg::HALF_PI_Q30) begin
            ang = -pps_pkg::PI_Q30 - alpha_w;
        end else begin
            ang = alpha_w;
        end

        smag   = s_reg[XW-1] ? 32'(-s_reg) : s_reg[31:0];
        thmag  = atan_reg[ZW-1] ? 32'(-atan_reg) : atan_reg[31:0];
        y2     = {prod_reg[62:0], 1'b0};
        xl     = {11'd0, cfg.look_ahead, 30'd0};
        t_full = (prod_reg + 64'd536870912) >> 30;
        tval   = t_full[31:0];
        m_full = (prod_reg + 64'd8388608) >> 24;
        magv   = m_full[39:0];
        mag    = (magv > {24'd0, cfg.steer_limit}) ? cfg.steer_limit : magv[15:0];

        if (cfg.target_speed < pps_pkg::SPEED_MIN) begin
            spd = pps_pkg::SPEED_MIN;
        end else if (cfg.target_speed > pps_pkg::SPEED_MAX) begin
            spd = pps_pkg::SPEED_MAX;
        end else begin
            spd = cfg.target_speed;
        end
    end

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_MX:   begin mul_a = ux;                     mul_b = ux; end
            ST_MY:   begin mul_a = uy_reg;                 mul_b = uy_reg; end
            ST_LA:   begin mul_a = 32'(cfg.look_ahead);    mul_b = 32'(cfg.look_ahead); end
            ST_M1:   begin mul_a = 32'(cfg.wbase);         mul_b = smag; end
            ST_M2:   begin mul_a = thmag;                  mul_b = pps_pkg::DEG_PER_RAD; end
            ST_M3:   begin mul_a = tval;                   mul_b = 32'(cfg.steer_ratio); end
            default: begin mul_a = '0;                     mul_b = '0; end
        endcase
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
    end

    always_comb begin
        creq       = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (in_acc && req_type) begin
                state_next = (cnt_reg < CW'(2)) ? ST_OUT : ST_RD;
            end
            ST_RD:   state_next = ST_MX;
            ST_MX:   state_next = ST_MY;
            ST_MY:   state_next = ST_CMP;
            ST_CMP: begin
                if (!at_last) begin
                    state_next = ST_RD;
                end else begin
                    state_next = phase2_reg ? ST_ATAN : ST_LA;
                end
            end
            ST_LA:   state_next = ST_LA2;
            ST_LA2:  state_next = ({1'b0, start_reg} > last) ? ST_ATAN : ST_RD;
            ST_ATAN: begin
                if (dxt == '0 && dyt == '0) begin
                    state_next = ST_SIN;
                end else begin
                    creq.start  = 1'b1;
                    creq.vector = 1'b1;
                    creq.x = XW'(dxt[32] ? 33'(-dxt) : dxt);
                    creq.y = XW'(dyt[32] ? 33'(-dyt) : dyt);
                    state_next = ST_ATW;
                end
            end
            ST_ATW:  if (cdone) state_next = ST_SIN;
            ST_SIN: begin
                creq.start = 1'b1;
                creq.x     = pps_pkg::GAIN_Q30;
                creq.z     = ang;
                state_next = ST_SINW;
            end
            ST_SINW: if (cdone) state_next = ST_M1;
            ST_M1:   state_next = ST_M1W;
            ST_M1W: begin
                if (cfg.look_ahead == '0 && y2 == '0) begin
                    state_next = ST_M2;
                end else begin
                    creq.start  = 1'b1;
                    creq.vector = 1'b1;
                    creq.x      = xl;
                    creq.y      = y2;
                    state_next  = ST_THW;
                end
            end
            ST_THW:  if (cdone) state_next = ST_M2;
            ST_M2:   state_next = ST_M3;
            ST_M3:   state_next = ST_M4;
            ST_M4:   state_next = ST_OUT;
            ST_OUT:  if (!out_valid_reg || out_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            start_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (ram_we) begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (state_reg == ST_ATAN) begin
                start_reg <= found_reg ? tgt_reg : '0;
            end
            if (state_reg == ST_OUT && (!out_valid_reg || out_ready)) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                cx_reg     <= car_x;
                cy_reg     <= car_y;
                hd_reg     <= car_heading;
                idx_reg    <= '0;
                phase2_reg <= 1'b0;
                closest_reg <= '0;
                res_reg    <= '0;
            end
            ST_MX: begin
                wx_reg <= px;
                wy_reg <= py;
                uy_reg <= uyw;
            end
            ST_MY: sx_reg <= prod_reg;
            ST_CMP: begin
                if (!phase2_reg) begin
                    if (idx_reg == '0) begin
                        w0x_reg <= wx_reg;
                        w0y_reg <= wy_reg;
                    end
                    if (idx_reg == '0 || dsum < best_reg) begin
                        best_reg    <= dsum;
                        closest_reg <= idx_reg;
                        cbx_reg     <= wx_reg;
                        cby_reg     <= wy_reg;
                    end
                end else if (la2_reg < dsum && (!found_reg || dsum < best_reg)) begin
                    best_reg  <= dsum;
                    tgt_reg   <= idx_reg;
                    tx_reg    <= wx_reg;
                    ty_reg    <= wy_reg;
                    found_reg <= 1'b1;
                end
                if (!at_last) begin
                    idx_reg <= idx_reg + 1'b1;
                end
            end
            ST_LA2: begin
                la2_reg    <= DW'(prod_reg);
                found_reg  <= 1'b0;
                phase2_reg <= 1'b1;
                idx_reg    <= start_reg;
            end
            ST_ATAN: begin
                tgt_reg   <= found_reg ? tgt_reg : '0;
                tx_reg    <= txu;
                ty_reg    <= tyu;
                dxneg_reg <= dxt[32];
                dyneg_reg <= dyt[32];
                atan_reg  <= '0;
            end
            ST_ATW:  if (cdone) atan_reg <= atan_fix;
            ST_SINW: if (cdone) s_reg <= cy_out;
            ST_M1W:  atan_reg <= '0;
            ST_THW:  if (cdone) atan_reg <= cz_out;
            ST_M4: begin
                res_reg.steer_cmd     <= (!s_reg[XW-1] && s_reg != '0) ?
                                         -$signed({1'b0, mag}) : $signed({1'b0, mag});
                res_reg.speed_cmd     <= spd[10:0];
                res_reg.closest_index <= 10'(closest_reg);
                res_reg.target_index  <= 10'(tgt_reg);
                res_reg.tgt_x         <= tx_reg;
                res_reg.tgt_y         <= ty_reg;
                res_reg.path_ok       <= 1'b1;
            end
            ST_OUT:  if (!out_valid_reg || out_ready) out_reg <= res_reg;
            default: ;
        endcase
    end

    assign out_valid = out_valid_reg;
    assign res       = out_reg;

endmodule

>>> rtl/core/pure_pursuit_steering.sv
// Append beat: gives no result; the next beat can be taken in the following cycle.
// Pose beat: the result is set by up to two scans of the waypoint RAM (each point read,
// squared in x and in y and compared in turn through one shared 32x32 multiplier) and
// up to three 30-step passes of one CORDIC unit. One beat at a time.
// Reset (aresetn low, synchronous): point count and search start cleared, registers
// back to defaults, result channel empty; waypoint RAM is not cleared.
module pure_pursuit_steering (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [143:0] s_tdata,   // wp_x, wp_y, car_x, car_y, car_heading
    input  logic [0:0]   s_tuser,   // req_type
    output logic         m_tvalid,
    input  logic         m_tready,
    // steer_cmd, speed_cmd, closest_index, target_index, tgt_x, tgt_y
    output logic [111:0] m_tdata,
    output logic [0:0]   m_tuser,   // path_ok
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    pps_pkg::cfg_t cfg_reg;
    pps_pkg::res_t res;
    logic          wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.look_ahead   <= 23'd131072;
            cfg_reg.target_speed <= 13'd768;
            cfg_reg.wbase        <= 20'd185631;
            cfg_reg.steer_ratio  <= 14'd3950;
            cfg_reg.steer_limit  <= 16'd34560;
        end else if (wr_en) begin
            unique case (paddr[4:2])
                pps_pkg::REG_LOOK_AHEAD:  cfg_reg.look_ahead   <= pwdata[22:0];
                pps_pkg::REG_TARGET_SPD:  cfg_reg.target_speed <= pwdata[12:0];
                pps_pkg::REG_WHEEL_BASE:  cfg_reg.wbase        <= pwdata[19:0];
                pps_pkg::REG_STEER_RATIO: cfg_reg.steer_ratio  <= pwdata[13:0];
                pps_pkg::REG_STEER_LIMIT: cfg_reg.steer_limit  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            pps_pkg::REG_LOOK_AHEAD:  prdata = 32'(cfg_reg.look_ahead);
            pps_pkg::REG_TARGET_SPD:  prdata = 32'(cfg_reg.target_speed);
            pps_pkg::REG_WHEEL_BASE:  prdata = 32'(cfg_reg.wbase);
            pps_pkg::REG_STEER_RATIO: prdata = 32'(cfg_reg.steer_ratio);
            pps_pkg::REG_STEER_LIMIT: prdata = 32'(cfg_reg.steer_limit);
            default:                  prdata = '0;
        endcase
    end

    pps_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .req_type    (s_tuser[0]),
        .wp_x        (s_tdata[31:0]),
        .wp_y        (s_tdata[63:32]),
        .car_x       (s_tdata[95:64]),
        .car_y       (s_tdata[127:96]),
        .car_heading (s_tdata[143:128]),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .res         (res)
    );

    assign m_tdata = {res.tgt_y, res.tgt_x, res.target_index, res.closest_index,
                      res.speed_cmd, res.steer_cmd};
    assign m_tuser = res.path_ok;

endmodule

>>> rtl/core/pps_checker.sv
module pps_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [111:0] m_tdata,
    input logic [0:0]   m_tuser
);

    // stalled beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_short: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata == '0)
        else $error("invalid path beat not all zero");

    a_speed: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata[27:17] >= 11'd256 && m_tdata[27:17] <= 11'd1536)
        else $error("speed out of clamp range");

endmodule

bind pure_pursuit_steering pps_checker u_pps_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

>>> test/pure_pursuit_steering_test.sv
`timescale 1ns / 100ps

module pure_pursuit_steering_test;

    localparam int  CYCLE_LIMIT = 2000000;
    localparam int  UNUSED_REG  = 5;
    localparam bit  REQ_APPEND  = 1'b0;
    localparam bit  REQ_POSE    = 1'b1;
    localparam int  SETTLE      = 40;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [143:0] s_tdata = '0;
    logic [0:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [111:0] m_tdata;
    logic [0:0]   m_tuser;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [4:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;

    pure_pursuit_steering DUT (.*);

    initial forever #1 aclk = ~aclk;

    // predictor state
    longint           path_x [pps_pkg::MAX_POINTS];
    longint           path_y [pps_pkg::MAX_POINTS];
    int               n_points;
    int               scan_start;
    pps_pkg::cfg_t    cfg;
    pps_pkg::res_t    pending_cmds [$];
    longint    steer_tab [pps_pkg::CORDIC_STEPS] = '{
        843314856, 497837829, 263043836, 133525158, 67021686,
        33543515, 16775850, 8388437, 4194282, 2097149,
        1048575, 524287, 262143, 131071, 65535,
        32767, 16383, 8191, 4095, 2047,
        1023, 511, 255, 127, 63,
        31, 15, 8, 4, 2};

    int        errors = 0;
    int        results_seen = 0;
    int        cycles = 0;
    int        idle_pct = 0;
    int        stall_pct = 0;
    int        hold_left = 0;
    longint    walk_x = 0, walk_y = 0;

    function automatic logic [65:0] dist_sq(longint ax, longint ay, longint bx, longint by);
        logic [65:0] ux, uy;
        longint dx, dy;
        dx = ax - bx;
        dy = ay - by;
        ux = (dx < 0) ? -dx : dx;
        uy = (dy < 0) ? -dy : dy;
        return ux * ux + uy * uy;
    endfunction

    function automatic longint bearing(longint dy, longint dx);
        longint x, y, z, nx;
        if (dx == 0 && dy == 0) return 0;
        x = (dx < 0) ? -dx : dx;
        y = (dy < 0) ? -dy : dy;
        z = 0;
        for (int i = 0; i < pps_pkg::CORDIC_STEPS; i++) begin
            if (y >= 0) begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z += steer_tab[i];
            end else begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z -= steer_tab[i];
            end
            x = nx;
        end
        if (dx < 0) z = longint'(pps_pkg::PI_Q30) - z;
        if (dy < 0) z = -z;
        return z;
    endfunction

    function automatic longint sine(longint a);
        longint x, y, nx;
        x = longint'(pps_pkg::GAIN_Q30);
        y = 0;
        if (a > longint'(pps_pkg::HALF_PI_Q30)) a = longint'(pps_pkg::PI_Q30) - a;
        if (a < -longint'(pps_pkg::HALF_PI_Q30)) a = -longint'(pps_pkg::PI_Q30) - a;
        for (int i = 0; i < pps_pkg::CORDIC_STEPS; i++) begin
            if (a >= 0) begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                a -= steer_tab[i];
            end else begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                a += steer_tab[i];
            end
            x = nx;
        end
        return y;
    endfunction

    function automatic pps_pkg::res_t steer_for_pose(longint cx, longint cy, longint hd);
        pps_pkg::res_t r;
        logic [65:0]   best, d, la2;
        int            near_i, tgt;
        bit            found;
        longint        alpha, s, theta, smag;
        logic [63:0]   t, mag, spd;
        r = '0;
        if (n_points < 2) return r;
        best = dist_sq(path_x[0], path_y[0], cx, cy);
        near_i = 0;
        for (int i = 1; i + 1 < n_points; i++) begin
            d = dist_sq(path_x[i], path_y[i], cx, cy);
            if (d < best) begin
                best = d;
                near_i = i;
            end
        end
        la2 = 66'(cfg.look_ahead) * 66'(cfg.look_ahead);
        found = 0;
        tgt = 0;
        for (int i = scan_start; i + 1 < n_points; i++) begin
            d = dist_sq(path_x[i], path_y[i], path_x[near_i], path_y[near_i]);
            if (d > la2 && (!found || d < best)) begin
                best = d;
                tgt = i;
                found = 1;
            end
        end
        scan_start = tgt;
        alpha = bearing(path_y[tgt] - cy, path_x[tgt] - cx) - hd * 131072;
        while (alpha > longint'(pps_pkg::PI_Q30)) alpha -= longint'(pps_pkg::TWO_PI_Q30);
        while (alpha <= -longint'(pps_pkg::PI_Q30)) alpha += longint'(pps_pkg::TWO_PI_Q30);
        s = sine(alpha);
        smag = (s < 0) ? -s : s;
        theta = bearing(2 * longint'(cfg.wbase) * smag, longint'(cfg.look_ahead) <<< 30);
        t = (64'((theta < 0) ? -theta : theta) * 64'(pps_pkg::DEG_PER_RAD)
             + (64'd1 << 29)) >> 30;
        mag = (t * 64'(cfg.steer_ratio) + (64'd1 << 23)) >> 24;
        if (mag > 64'(cfg.steer_limit)) mag = 64'(cfg.steer_limit);
        spd = 64'(cfg.target_speed);
        if (spd < 64'(pps_pkg::SPEED_MIN)) spd = 64'(pps_pkg::SPEED_MIN);
        if (spd > 64'(pps_pkg::SPEED_MAX)) spd = 64'(pps_pkg::SPEED_MAX);
        r.steer_cmd     = (s > 0) ? -17'(mag) : 17'(mag);
        r.speed_cmd     = 11'(spd);
        r.closest_index = 10'(near_i);
        r.target_index  = 10'(tgt);
        r.tgt_x         = 32'(path_x[tgt]);
        r.tgt_y         = 32'(path_y[tgt]);
        r.path_ok       = 1'b1;
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        errors++;
        $display("mismatch at cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
    endtask

    task automatic apb_write(int idx, logic [31:0] value);
        @(negedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 5'(idx * 4);
        pwdata <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        case (idx)
            pps_pkg::REG_LOOK_AHEAD:  cfg.look_ahead   = value[22:0];
            pps_pkg::REG_TARGET_SPD:  cfg.target_speed = value[12:0];
            pps_pkg::REG_WHEEL_BASE:  cfg.wbase        = value[19:0];
            pps_pkg::REG_STEER_RATIO: cfg.steer_ratio  = value[13:0];
            pps_pkg::REG_STEER_LIMIT: cfg.steer_limit  = value[15:0];
            default: ;
        endcase
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic send_beat(bit req, logic [31:0] wx, logic [31:0] wy,
                             logic [31:0] cx, logic [31:0] cy, logic [15:0] hd);
        @(negedge aclk);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= req;
        s_tdata <= {hd, cy, cx, wy, wx};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (req == REQ_APPEND) begin
            if (n_points < pps_pkg::MAX_POINTS) begin
                path_x[n_points] = longint'(signed'(wx));
                path_y[n_points] = longint'(signed'(wy));
                n_points++;
            end
        end else begin
            pending_cmds.insert(pending_cmds.size(),
                steer_for_pose(longint'(signed'(cx)), longint'(signed'(cy)),
                               longint'(signed'(hd))));
        end
    endtask

    task automatic wait_idle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_cmds.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    function automatic logic [15:0] rand_heading();
        return 16'($urandom_range(51472) - 25736);
    endfunction

    function automatic logic [31:0] clip32(longint v);
        if (v > 64'sd2147483647) return 32'h7fffffff;
        if (v < -64'sd2147483648) return 32'h80000000;
        return 32'(v);
    endfunction

    task automatic path_point();
        walk_x += longint'($urandom_range(196608)) - 65536;
        walk_y += longint'($urandom_range(196608)) - 65536;
        send_beat(REQ_APPEND, clip32(walk_x), clip32(walk_y), $urandom, $urandom,
                  16'($urandom));
    endtask

    task automatic pose_near_path();
        int k;
        k = (n_points > 0) ? $urandom_range(n_points - 1) : 0;
        send_beat(REQ_POSE, $urandom, $urandom,
                  clip32(path_x[k] + longint'($urandom_range(131072)) - 65536),
                  clip32(path_y[k] + longint'($urandom_range(131072)) - 65536),
                  rand_heading());
    endtask

    task automatic random_items(int n);
        int pick;
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(99);
            if (pick < 40) path_point();
            else if (pick < 75) pose_near_path();
            else if (pick < 88)
                send_beat(REQ_POSE, $urandom, $urandom, $urandom, $urandom, rand_heading());
            else
                send_beat(REQ_APPEND, $urandom, $urandom, $urandom, $urandom, 16'($urandom));
        end
    endtask

    task automatic test_short_path();
        send_beat(REQ_POSE, 0, 0, 32'h7fffffff, 32'h80000000, 16'sd25736);
        send_beat(REQ_APPEND, 0, 0, 32'hffffffff, 32'hffffffff, 16'hffff);
        send_beat(REQ_POSE, 32'hffffffff, 32'hffffffff, 0, 0, -16'sd25736);
        wait_idle();
    endtask

    task automatic test_directed_path();
        send_beat(REQ_APPEND, 32'h00020000, 0, 0, 0, '0);
        send_beat(REQ_APPEND, 32'h00040000, 32'h00010000, 0, 0, '0);
        send_beat(REQ_APPEND, 32'h00080000, 32'h00030000, 0, 0, '0);
        send_beat(REQ_APPEND, 32'h000c0000, 32'h00080000, 0, 0, '0);
        // car at the origin, on stored waypoints and beside the path
        send_beat(REQ_POSE, 0, 0, 0, 0, 16'sd25736);
        send_beat(REQ_POSE, 0, 0, 32'h00040000, 32'h00010000, -16'sd25736);
        send_beat(REQ_POSE, 0, 0, 32'h00030000, 32'hfffe0000, '0);
        send_beat(REQ_POSE, 0, 0, 32'h000c0000, 32'h00080000, 16'sd12868);
        // far corners of the coordinate range
        send_beat(REQ_APPEND, 32'h80000000, 32'h7fffffff, 0, 0, '0);
        send_beat(REQ_APPEND, 32'h7fffffff, 32'h80000000, 0, 0, '0);
        send_beat(REQ_APPEND, 32'h80000000, 32'h80000000, 0, 0, '0);
        send_beat(REQ_POSE, 0, 0, 32'h7fffffff, 32'h7fffffff, 16'sd25736);
        send_beat(REQ_POSE, 0, 0, 32'h80000000, 32'h80000000, -16'sd25736);
        send_beat(REQ_POSE, 0, 0, 32'h00000000, 32'h80000000, 16'sd1);
        wait_idle();
    endtask

    task automatic test_config_sweep();
        apb_write(pps_pkg::REG_LOOK_AHEAD, 16384);
        apb_write(pps_pkg::REG_TARGET_SPD, 0);
        apb_write(pps_pkg::REG_WHEEL_BASE, 655360);
        apb_write(pps_pkg::REG_STEER_RATIO, 8192);
        apb_write(pps_pkg::REG_STEER_LIMIT, 0);
        random_items(8);
        wait_idle();
        apb_write(pps_pkg::REG_LOOK_AHEAD, 4194304);
        apb_write(pps_pkg::REG_TARGET_SPD, 4096);
        apb_write(pps_pkg::REG_WHEEL_BASE, 0);
        apb_write(pps_pkg::REG_STEER_RATIO, 0);
        apb_write(pps_pkg::REG_STEER_LIMIT, 57600);
        random_items(8);
        wait_idle();
        // zero look-ahead: every point off the closest one qualifies
        apb_write(pps_pkg::REG_LOOK_AHEAD, 0);
        apb_write(pps_pkg::REG_WHEEL_BASE, 655360);
        apb_write(pps_pkg::REG_STEER_RATIO, 8192);
        apb_write(pps_pkg::REG_TARGET_SPD, 300);
        apb_write(UNUSED_REG, 32'hffffffff);
        random_items(8);
        wait_idle();
        apb_write(pps_pkg::REG_LOOK_AHEAD, 131072);
        apb_write(pps_pkg::REG_TARGET_SPD, 768);
        apb_write(pps_pkg::REG_WHEEL_BASE, 185631);
        apb_write(pps_pkg::REG_STEER_RATIO, 3950);
        apb_write(pps_pkg::REG_STEER_LIMIT, 34560);
    endtask

    task automatic test_idle_phases();
        int idle_set [4] = '{0, 82, 0, 9};
        int stall_set [4] = '{0, 0, 82, 9};
        for (int p = 0; p < 4; p++) begin
            idle_pct = idle_set[p];
            stall_pct = stall_set[p];
            random_items(55);
            wait_idle();
            apb_write(pps_pkg::REG_LOOK_AHEAD, 16384 + $urandom_range(300000));
            apb_write(pps_pkg::REG_STEER_LIMIT, $urandom_range(57600));
        end
        idle_pct = 0;
        stall_pct = 0;
    endtask

    task automatic test_backpressure();
        hold_left = 3000;
        for (int i = 0; i < 6; i++) pose_near_path();
        wait_idle();
    endtask

    task automatic test_late_points();
        for (int i = 0; i < 3; i++) path_point();
        for (int i = 0; i < 3; i++) pose_near_path();
        wait_idle();
    endtask

    always @(negedge aclk) begin
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin
        pps_pkg::res_t want;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("tb: failure");
            $finish;
        end
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (pending_cmds.size() == 0) begin
                report_mismatch("unexpected beat", 1, 0);
            end else begin
                want = pending_cmds.pop_front();
                if (m_tdata[16:0] != want.steer_cmd)
                    report_mismatch("steer_cmd", signed'(m_tdata[16:0]), want.steer_cmd);
                if (m_tdata[27:17] != want.speed_cmd)
                    report_mismatch("speed_cmd", m_tdata[27:17], want.speed_cmd);
                if (m_tdata[37:28] != want.closest_index)
                    report_mismatch("closest_index", m_tdata[37:28], want.closest_index);
                if (m_tdata[47:38] != want.target_index)
                    report_mismatch("target_index", m_tdata[47:38], want.target_index);
                if (m_tdata[79:48] != want.tgt_x)
                    report_mismatch("tgt_x", signed'(m_tdata[79:48]), want.tgt_x);
                if (m_tdata[111:80] != want.tgt_y)
                    report_mismatch("tgt_y", signed'(m_tdata[111:80]), want.tgt_y);
                if (m_tuser[0] != want.path_ok)
                    report_mismatch("path_ok", m_tuser[0], want.path_ok);
            end
        end
    end

    initial begin
        n_points = 0;
        scan_start = 0;
        cfg.look_ahead = 131072;
        cfg.target_speed = 768;
        cfg.wbase = 185631;
        cfg.steer_ratio = 3950;
        cfg.steer_limit = 34560;
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        test_short_path();
        test_directed_path();
        test_config_sweep();
        test_idle_phases();
        test_backpressure();
        test_late_points();
        if (pending_cmds.size() != 0)
            report_mismatch("results missing", 0, pending_cmds.size());
        $display("covered short paths, corner coordinates, register extremes, four idle mixes");
        $display("and a long output stall; %0d results checked", results_seen);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

>>> pure_pursuit_steering.f
rtl/core/pps_pkg.sv
rtl/core/pps_ram.sv
rtl/core/pps_cordic.sv
rtl/core/pps_core.sv
rtl/core/pure_pursuit_steering.sv
rtl/core/pps_checker.sv
test/pure_pursuit_steering_test.sv
